// File: rtl/ps2hc_pkg.sv
`default_nettype none

package ps2hc_pkg;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_RX       = 3'd1,
        PH_INHIBIT  = 3'd2,
        PH_TXBITS   = 3'd3,
        PH_ACK_FALL = 3'd4,
        PH_ACK_RISE = 3'd5
    } t_phase;

    localparam logic [15:0] INHIBIT_RESET = 16'd110;
    localparam logic [15:0] TIMER_MAX     = 16'hFFFF;

    // Bit counter marks within a frame.
    localparam logic [3:0] CNT_DATA_BITS = 4'd8;
    localparam logic [3:0] CNT_PARITY    = 4'd9;
    localparam logic [3:0] CNT_STOP      = 4'd10;

endpackage

`default_nettype wire

// File: rtl/ps2_host_controller_unit.sv
`default_nettype none

// Channel  | Handshake                | Payload
// ---------+--------------------------+-----------------------------------------------
// input    | i_in_valid / o_in_ready  | i_req_type, i_clk_in, i_dat_in, i_tx_byte
// result   | o_out_valid / i_out_ready| o_clk_pull_low, o_dat_pull_low, o_rx_valid,
//          |                          | o_rx_byte, o_rx_parity_error, o_tx_done, o_busy_res
// config   | i_cfg_we (no wait)       | i_cfg_data (inhibit ticks)
//
// One line sample per cycle: a transaction is taken whenever the result register is
// empty or being emptied, and its result is registered there on the next edge.
// The link state and the result register update in the same edge, so throughput is one
// sample per clock; a stalled result stops intake only while i_out_ready stays low.
// Synchronous active-low reset returns the link to idle, clock level high, and the
// inhibit time to 110 ticks.

module ps2_host_controller_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_req_type,
    input  wire logic        i_clk_in,
    input  wire logic        i_dat_in,
    input  wire logic [7:0]  i_tx_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_clk_pull_low,
    output logic             o_dat_pull_low,
    output logic             o_rx_valid,
    output logic [7:0]       o_rx_byte,
    output logic             o_rx_parity_error,
    output logic             o_tx_done,
    output logic             o_busy_res
);

    logic [15:0]         r_inhibit_ticks;
    ps2hc_pkg::t_phase   r_phase, n_phase;
    logic                r_last_clk, n_last_clk;
    logic [3:0]          r_bit_cnt, n_bit_cnt;
    logic [7:0]          r_shift, n_shift;
    logic                r_parity, n_parity;
    logic [15:0]         r_timer, n_timer;

    logic                r_out_valid;
    logic                r_clk_pull_low, n_clk_pull_low;
    logic                r_dat_pull_low, n_dat_pull_low;
    logic                r_rx_valid, n_rx_valid;
    logic [7:0]          r_rx_byte, n_rx_byte;
    logic                r_rx_err, n_rx_err;
    logic                r_tx_done, n_tx_done;
    logic                r_busy, n_busy;

    logic                w_accept;
    logic                w_fall;
    logic                w_rise;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_fall     = r_last_clk && !i_clk_in;
    assign w_rise     = !r_last_clk && i_clk_in;

    always_comb begin
        n_phase    = r_phase;
        n_last_clk = i_clk_in;
        n_bit_cnt  = r_bit_cnt;
        n_shift    = r_shift;
        n_parity   = r_parity;
        n_timer    = r_timer;
        n_rx_valid = 1'b0;
        n_rx_byte  = 8'd0;
        n_rx_err   = 1'b0;
        n_tx_done  = 1'b0;

        case (r_phase)
            ps2hc_pkg::PH_RX: begin
                if (w_fall) begin
                    if (r_bit_cnt < ps2hc_pkg::CNT_DATA_BITS) begin
                        n_shift   = r_shift | (8'(i_dat_in) << r_bit_cnt[2:0]);
                        n_parity  = r_parity ^ i_dat_in;
                        n_bit_cnt = r_bit_cnt + 4'd1;
                    end else if (r_bit_cnt == ps2hc_pkg::CNT_DATA_BITS) begin
                        // Parity left at one means the frame was not odd.
                        n_parity  = r_parity ^ i_dat_in;
                        n_bit_cnt = r_bit_cnt + 4'd1;
                    end else begin
                        n_rx_valid = 1'b1;
                        n_rx_byte  = r_shift;
                        n_rx_err   = r_parity;
                        n_phase    = ps2hc_pkg::PH_IDLE;
                        n_bit_cnt  = 4'd0;
                    end
                end
            end
            ps2hc_pkg::PH_INHIBIT: begin
                if (r_timer != ps2hc_pkg::TIMER_MAX) begin
                    n_timer = r_timer + 16'd1;
                end
                if (n_timer >= r_inhibit_ticks) begin
                    n_phase   = ps2hc_pkg::PH_TXBITS;
                    n_bit_cnt = 4'd0;
                end
            end
            ps2hc_pkg::PH_TXBITS: begin
                if (w_fall) begin
                    if (r_bit_cnt < ps2hc_pkg::CNT_DATA_BITS) begin
                        n_parity = r_parity ^ r_shift[r_bit_cnt[2:0]];
                    end
                    if (r_bit_cnt < ps2hc_pkg::CNT_PARITY) begin
                        n_bit_cnt = r_bit_cnt + 4'd1;
                    end else begin
                        n_bit_cnt = ps2hc_pkg::CNT_STOP;
                        n_phase   = ps2hc_pkg::PH_ACK_FALL;
                    end
                end
            end
            ps2hc_pkg::PH_ACK_FALL: begin
                if (w_fall) begin
                    n_phase = ps2hc_pkg::PH_ACK_RISE;
                end
            end
            ps2hc_pkg::PH_ACK_RISE: begin
                if (w_rise) begin
                    n_phase   = ps2hc_pkg::PH_IDLE;
                    n_tx_done = 1'b1;
                    n_bit_cnt = 4'd0;
                end
            end
            default: begin
                // Idle, and any stray code behaves the same way. A send request wins
                // over a falling edge seen in the same sample.
                n_phase = ps2hc_pkg::PH_IDLE;
                if (i_req_type) begin
                    n_phase   = ps2hc_pkg::PH_INHIBIT;
                    n_timer   = 16'd0;
                    n_shift   = i_tx_byte;
                    n_bit_cnt = 4'd0;
                    n_parity  = 1'b1;
                end else if (w_fall) begin
                    n_phase   = ps2hc_pkg::PH_RX;
                    n_bit_cnt = 4'd0;
                    n_shift   = 8'd0;
                    n_parity  = 1'b1;
                end
            end
        endcase

        n_clk_pull_low = (n_phase == ps2hc_pkg::PH_INHIBIT);
        n_busy         = (n_phase != ps2hc_pkg::PH_IDLE);

        // Data line drive follows the updated transmit position.
        n_dat_pull_low = 1'b0;
        if (n_phase == ps2hc_pkg::PH_TXBITS) begin
            if (n_bit_cnt == 4'd0) begin
                n_dat_pull_low = 1'b1;
            end else if (n_bit_cnt <= ps2hc_pkg::CNT_DATA_BITS) begin
                n_dat_pull_low = !n_shift[3'(n_bit_cnt - 4'd1)];
            end else if (n_bit_cnt == ps2hc_pkg::CNT_PARITY) begin
                n_dat_pull_low = !n_parity;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inhibit_ticks <= ps2hc_pkg::INHIBIT_RESET;
        end else if (i_cfg_we) begin
            r_inhibit_ticks <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= ps2hc_pkg::PH_IDLE;
            r_last_clk <= 1'b1;
            r_bit_cnt  <= 4'd0;
            r_shift    <= 8'd0;
            r_parity   <= 1'b1;
            r_timer    <= 16'd0;
        end else if (w_accept) begin
            r_phase    <= n_phase;
            r_last_clk <= n_last_clk;
            r_bit_cnt  <= n_bit_cnt;
            r_shift    <= n_shift;
            r_parity   <= n_parity;
            r_timer    <= n_timer;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_clk_pull_low <= n_clk_pull_low;
            r_dat_pull_low <= n_dat_pull_low;
            r_rx_valid     <= n_rx_valid;
            r_rx_byte      <= n_rx_byte;
            r_rx_err       <= n_rx_err;
            r_tx_done      <= n_tx_done;
            r_busy         <= n_busy;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_clk_pull_low    = r_clk_pull_low;
    assign o_dat_pull_low    = r_dat_pull_low;
    assign o_rx_valid        = r_rx_valid;
    assign o_rx_byte         = r_rx_byte;
    assign o_rx_parity_error = r_rx_err;
    assign o_tx_done         = r_tx_done;
    assign o_busy_res        = r_busy;

`ifndef SYNTHESIS
    a_req_starts_inhibit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && r_phase == ps2hc_pkg::PH_IDLE && i_req_type)
        |=> (r_phase == ps2hc_pkg::PH_INHIBIT && o_clk_pull_low))
        else $error("send request did not enter the inhibit phase");

    a_rx_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_rx_valid || o_tx_done)) |-> !o_busy_res)
        else $error("frame completed but link still busy");

    a_inhibit_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_clk_pull_low) |-> !o_dat_pull_low)
        else $error("data driven during clock inhibit");

    a_bit_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_cnt <= ps2hc_pkg::CNT_STOP)
        else $error("bit counter out of range");

    a_state_holds_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> $stable(r_phase) && $stable(r_bit_cnt))
        else $error("link state moved without a transaction");
`endif

endmodule

`default_nettype wire

// File: tb/testbench.sv
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic       req;
        logic       clk;
        logic       dat;
        logic [7:0] txb;
    } t_line_tick;

    typedef struct packed {
        logic       clk_pull_low;
        logic       dat_pull_low;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic       rx_parity_error;
        logic       tx_done;
        logic       busy_res;
    } t_link_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [15:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        i_req_type = 1'b0;
    logic        i_clk_in = 1'b1;
    logic        i_dat_in = 1'b1;
    logic [7:0]  i_tx_byte = '0;
    logic        i_out_ready = 1'b0;
    wire logic   o_in_ready;
    wire logic   o_out_valid;
    wire logic   o_clk_pull_low;
    wire logic   o_dat_pull_low;
    wire logic   o_rx_valid;
    wire logic [7:0] o_rx_byte;
    wire logic   o_rx_parity_error;
    wire logic   o_tx_done;
    wire logic   o_busy_res;

    ps2_host_controller_unit dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_req_type        (i_req_type),
        .i_clk_in          (i_clk_in),
        .i_dat_in          (i_dat_in),
        .i_tx_byte         (i_tx_byte),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_clk_pull_low    (o_clk_pull_low),
        .o_dat_pull_low    (o_dat_pull_low),
        .o_rx_valid        (o_rx_valid),
        .o_rx_byte         (o_rx_byte),
        .o_rx_parity_error (o_rx_parity_error),
        .o_tx_done         (o_tx_done),
        .o_busy_res        (o_busy_res)
    );

    t_line_tick   tick_q[$];
    t_link_result link_expect_q[$];

    // Shadow copy of the link state, advanced once per accepted sample.
    ps2hc_pkg::t_phase lk_phase = ps2hc_pkg::PH_IDLE;
    logic        lk_last_clk = 1'b1;
    logic [3:0]  lk_bits = '0;
    logic [7:0]  lk_shift = '0;
    logic        lk_par = 1'b1;
    logic [15:0] lk_timer = '0;
    logic [15:0] lk_inhibit = ps2hc_pkg::INHIBIT_RESET;

    int n_sent = 0;
    int n_results = 0;
    int n_errors = 0;
    int n_rx_bytes = 0;
    int n_sends = 0;
    int send_gap = 0;
    int hold_left = 0;
    int press_left = 0;
    bit press_done = 1'b0;
    logic accepted;
    t_line_tick nxt;
    t_link_result got;
    t_link_result want;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_link_result link_step(input logic req, input logic clk,
                                               input logic dat, input logic [7:0] txb);
        t_link_result r;
        logic fall;
        logic rise;
        r = '0;
        fall = lk_last_clk && !clk;
        rise = !lk_last_clk && clk;
        case (lk_phase)
            ps2hc_pkg::PH_IDLE: begin
                // A send request takes priority over a falling edge.
                if (req) begin
                    lk_phase = ps2hc_pkg::PH_INHIBIT;
                    lk_timer = '0;
                    lk_shift = txb;
                    lk_bits = '0;
                    lk_par = 1'b1;
                end else if (fall) begin
                    lk_phase = ps2hc_pkg::PH_RX;
                    lk_bits = '0;
                    lk_shift = '0;
                    lk_par = 1'b1;
                end
            end
            ps2hc_pkg::PH_RX: begin
                if (fall) begin
                    if (lk_bits < ps2hc_pkg::CNT_DATA_BITS) begin
                        lk_shift = lk_shift | (8'(dat) << lk_bits[2:0]);
                        lk_par = lk_par ^ dat;
                        lk_bits = lk_bits + 4'd1;
                    end else if (lk_bits == ps2hc_pkg::CNT_DATA_BITS) begin
                        lk_par = lk_par ^ dat;
                        lk_bits = lk_bits + 4'd1;
                    end else begin
                        r.rx_valid = 1'b1;
                        r.rx_byte = lk_shift;
                        r.rx_parity_error = lk_par;
                        lk_phase = ps2hc_pkg::PH_IDLE;
                        lk_bits = '0;
                    end
                end
            end
            ps2hc_pkg::PH_INHIBIT: begin
                if (lk_timer != ps2hc_pkg::TIMER_MAX) lk_timer = lk_timer + 16'd1;
                if (lk_timer >= lk_inhibit) begin
                    lk_phase = ps2hc_pkg::PH_TXBITS;
                    lk_bits = '0;
                end
            end
            ps2hc_pkg::PH_TXBITS: begin
                if (fall) begin
                    if (lk_bits < ps2hc_pkg::CNT_DATA_BITS)
                        lk_par = lk_par ^ lk_shift[lk_bits[2:0]];
                    if (lk_bits < ps2hc_pkg::CNT_PARITY) begin
                        lk_bits = lk_bits + 4'd1;
                    end else begin
                        lk_bits = ps2hc_pkg::CNT_STOP;
                        lk_phase = ps2hc_pkg::PH_ACK_FALL;
                    end
                end
            end
            ps2hc_pkg::PH_ACK_FALL: begin
                if (fall) lk_phase = ps2hc_pkg::PH_ACK_RISE;
            end
            default: begin
                if (rise) begin
                    lk_phase = ps2hc_pkg::PH_IDLE;
                    r.tx_done = 1'b1;
                    lk_bits = '0;
                end
            end
        endcase
        lk_last_clk = clk;

        r.clk_pull_low = (lk_phase == ps2hc_pkg::PH_INHIBIT);
        if (lk_phase == ps2hc_pkg::PH_TXBITS) begin
            if (lk_bits == 4'd0)
                r.dat_pull_low = 1'b1;
            else if (lk_bits <= ps2hc_pkg::CNT_DATA_BITS)
                r.dat_pull_low = ~lk_shift[3'(lk_bits - 4'd1)];
            else if (lk_bits == ps2hc_pkg::CNT_PARITY)
                r.dat_pull_low = ~lk_par;
        end
        r.busy_res = (lk_phase != ps2hc_pkg::PH_IDLE);
        return r;
    endfunction

    // Mostly back to back, some short gaps, a few long ones, and every fourth
    // stretch of a hundred transactions with no gaps at all.
    function automatic int pick_gap(input int count);
        int r;
        if ((count / 100) % 4 == 3) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 25);
    endfunction

    task automatic push_tick(input logic req, input logic clk, input logic dat,
                             input logic [7:0] txb);
        t_line_tick t;
        t.req = req;
        t.clk = clk;
        t.dat = dat;
        t.txb = txb;
        tick_q.push_back(t);
    endtask

    task automatic idle_ticks(input int n);
        repeat (n) push_tick(1'b0, 1'b1, 1'b1, 8'h00);
    endtask

    // Device clock pulses: each bit is presented while clock is high and taken
    // on the falling edge. A request can be slipped into the fifth low phase.
    task automatic device_clocks(input logic [11:0] bits, input int n_bits, input bit busy_req);
        int h;
        for (int i = 0; i < n_bits; i++) begin
            h = $urandom_range(1, 2);
            repeat (h) push_tick(1'b0, 1'b1, bits[i], 8'h00);
            for (int j = 0; j < h; j++)
                push_tick(busy_req && i == 4 && j == 0, 1'b0, bits[i], 8'($urandom));
        end
        idle_ticks($urandom_range(1, 3));
    endtask

    task automatic receive_frame(input logic [7:0] b, input bit bad_par, input logic start_lvl,
                                 input bit busy_req);
        logic [11:0] bits;
        bits = {1'b1, 1'b1, (~^b) ^ bad_par, b, start_lvl};
        device_clocks(bits, 11, busy_req);
    endtask

    // Request, clock held low by the host for the inhibit time, then the
    // device clocks out ten bits plus the ack.
    task automatic send_frame(input logic [7:0] b, input logic [15:0] inhibit, input logic req_clk);
        int n;
        push_tick(1'b1, req_clk, 1'b1, b);
        n = (inhibit == 16'd0) ? 1 : int'(inhibit);
        n += $urandom_range(0, 2);
        repeat (n) push_tick(1'b0, 1'b0, 1'($urandom), 8'($urandom));
        idle_ticks($urandom_range(1, 2));
        device_clocks(12'($urandom), 11, 1'b0);
    endtask

    task automatic noise_ticks(input int n);
        repeat (n)
            push_tick($urandom_range(0, 3) == 0, 1'($urandom), 1'($urandom), 8'($urandom));
    endtask

    task automatic random_mix(input int n);
        int target;
        int r;
        int k;
        target = tick_q.size() + n;
        while (tick_q.size() < target) begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                receive_frame(8'($urandom), $urandom_range(0, 9) == 0,
                              $urandom_range(0, 7) == 0, $urandom_range(0, 9) == 0);
            end else if (r < 75) begin
                send_frame(8'($urandom), lk_inhibit, 1'b1);
            end else if (r < 87) begin
                // Truncated frame, sometimes completed by stray pulses afterwards.
                k = $urandom_range(1, 10);
                device_clocks(12'($urandom), k, 1'b0);
                if ($urandom_range(0, 1) == 1) device_clocks(12'($urandom), 11 - k, 1'b0);
            end else begin
                noise_ticks($urandom_range(1, 8));
            end
        end
    endtask

    // Sampled at the falling edge so that every transaction of the rising edge has settled.
    task automatic wait_idle();
        while (tick_q.size() != 0 || i_in_valid || link_expect_q.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_inhibit(input logic [15:0] v);
        wait_idle();
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        lk_inhibit = v;
    endtask

    // Driver: one line sample per transaction, predicted when it is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap = 0;
        end else begin
            accepted = i_in_valid && o_in_ready;
            if (accepted) begin
                link_expect_q.push_back(link_step(i_req_type, i_clk_in, i_dat_in, i_tx_byte));
                n_sent++;
            end
            if (!i_in_valid || accepted) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (tick_q.size() != 0) begin
                    nxt = tick_q.pop_front();
                    i_req_type <= nxt.req;
                    i_clk_in <= nxt.clk;
                    i_dat_in <= nxt.dat;
                    i_tx_byte <= nxt.txb;
                    i_in_valid <= 1'b1;
                    send_gap = pick_gap(n_sent);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result transaction with the oldest prediction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            hold_left = 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                got = '{o_clk_pull_low, o_dat_pull_low, o_rx_valid, o_rx_byte,
                        o_rx_parity_error, o_tx_done, o_busy_res};
                if (got.rx_valid) n_rx_bytes++;
                if (got.tx_done) n_sends++;
                if (link_expect_q.size() == 0) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("result %0d arrived with no prediction pending", n_results);
                end else if (got != link_expect_q[0]) begin
                    n_errors++;
                    want = link_expect_q[0];
                    if (n_errors <= 10) begin
                        $display("result %0d: expected clk_pl=%0b dat_pl=%0b rxv=%0b byte=%02h",
                                 n_results, want.clk_pull_low, want.dat_pull_low,
                                 want.rx_valid, want.rx_byte);
                        $display("    perr=%0b done=%0b busy=%0b",
                                 want.rx_parity_error, want.tx_done, want.busy_res);
                        $display("    got clk_pl=%0b dat_pl=%0b rxv=%0b byte=%02h",
                                 got.clk_pull_low, got.dat_pull_low, got.rx_valid,
                                 got.rx_byte);
                        $display("    perr=%0b done=%0b busy=%0b",
                                 got.rx_parity_error, got.tx_done, got.busy_res);
                    end
                end
                if (link_expect_q.size() != 0) void'(link_expect_q.pop_front());
                n_results++;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= (press_left == 0);
                hold_left = pick_gap(n_results);
            end
        end
    end

    // One long result stall while the driver keeps offering samples.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            press_left <= 0;
            press_done <= 1'b0;
        end else if (press_left != 0) begin
            press_left <= press_left - 1;
        end else if (!press_done && n_results >= 250) begin
            press_left <= 400;
            press_done <= 1'b1;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset inhibit time first, with the frame extremes and corner cases.
        idle_ticks(3);
        receive_frame(8'h00, 1'b0, 1'b0, 1'b0);
        receive_frame(8'hFF, 1'b1, 1'b0, 1'b0);
        receive_frame(8'h5A, 1'b0, 1'b1, 1'b0);
        receive_frame(8'h81, 1'b0, 1'b0, 1'b1);
        send_frame(8'hA5, lk_inhibit, 1'b1);
        idle_ticks(1);
        send_frame(8'h3C, lk_inhibit, 1'b0);
        send_frame(8'hFF, lk_inhibit, 1'b1);
        send_frame(8'h00, lk_inhibit, 1'b1);

        write_inhibit(16'd0);
        send_frame(8'h01, lk_inhibit, 1'b1);
        receive_frame(8'h01, 1'b0, 1'b0, 1'b0);
        random_mix(100);

        write_inhibit(16'd1);
        random_mix(150);

        // The longest inhibit time is only loaded; a send under it would take 65535 samples.
        write_inhibit(16'hFFFF);
        receive_frame(8'($urandom), 1'b0, 1'b0, 1'b0);

        write_inhibit(16'($urandom_range(2, 40)));
        random_mix(150);

        write_inhibit(16'd5);
        random_mix(150);

        wait_idle();
        repeat (4) @(posedge i_clk);

        $display("Checked %0d line samples under six inhibit settings, 0, 1 and 65535 too.",
                 n_results);
        $display("%0d bytes received, %0d sends completed, one 400-cycle result stall.",
                 n_rx_bytes, n_sends);
        if (n_errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("%0d mismatching results", n_errors);
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #100ms;
        $display("Timed out with %0d predictions pending", link_expect_q.size());
        $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire
